// ===== hw/rtl/wsw_pkg.sv =====
// Shared types, event codes and constants of the worker supervisor watchdog.
`timescale 1ns / 1ps
`default_nettype none
package wsw_pkg;

   localparam int TW = 48;
   localparam int SW = 16;
   localparam int CRASH_DEPTH_DEF  = 16;
   localparam int BACKOFF_UNIT_DEF = 1000;
   localparam logic [4:0] STEP_MAX  = 5'd31;
   localparam logic [4:0] SHIFT_MAX = 5'd30;
   localparam logic [SW-1:0] PEND_MAX = 16'hFFFF;

   // event codes
   localparam logic [3:0] EV_UPDATE   = 4'd0;
   localparam logic [3:0] EV_START    = 4'd1;
   localparam logic [3:0] EV_SPAWNED  = 4'd2;
   localparam logic [3:0] EV_EXIT     = 4'd3;
   localparam logic [3:0] EV_PING     = 4'd4;
   localparam logic [3:0] EV_PONG     = 4'd5;
   localparam logic [3:0] EV_FBEGIN   = 4'd6;
   localparam logic [3:0] EV_FDONE    = 4'd7;
   localparam logic [3:0] EV_SUBMIT   = 4'd8;
   localparam logic [3:0] EV_BUSY     = 4'd9;
   localparam logic [3:0] EV_RESTART  = 4'd10;
   localparam logic [3:0] EV_RESULT   = 4'd11;
   localparam logic [3:0] EV_TAKEPOIS = 4'd12;

   // action codes
   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_SPAWN = 2'd1;
   localparam logic [1:0] ACT_KILL  = 2'd2;

   // register indexes
   localparam logic [2:0] REG_STORM_WIN  = 3'd0;
   localparam logic [2:0] REG_STORM_CNT  = 3'd1;
   localparam logic [2:0] REG_BACKOFF    = 3'd2;
   localparam logic [2:0] REG_PONG       = 3'd3;
   localparam logic [2:0] REG_COMPILE    = 3'd4;
   localparam logic [2:0] REG_FRAME      = 3'd5;
   localparam logic [2:0] REG_PING       = 3'd6;

   typedef struct packed {
      logic [TW-1:0] storm_window;
      logic [3:0]    storm_count;
      logic [TW-1:0] backoff_cap;
      logic [TW-1:0] pong_wait;
      logic [TW-1:0] compile_wait;
      logic [TW-1:0] frame_wait;
      logic [TW-1:0] ping_period;
   } cfg_type;

   typedef struct packed {
      logic load;   // latch the accepted transfer
      logic exec;   // apply the event
      logic scan;   // purge scan cycle
      logic rd;     // read a ring entry
      logic chk;    // compare the entry read
      logic fin;    // close out a crash
      logic out;    // load the result register
   } cmd_type;

   typedef struct packed {
      logic exit_go;
      logic rd_go;
      logic older;
   } sts_type;

endpackage
`default_nettype wire

// ===== hw/rtl/wsw_ctrl.sv =====
// Sequencer of the worker supervisor watchdog.
`timescale 1ns / 1ps
`default_nettype none
module wsw_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire wsw_pkg::sts_type sts,
   output wsw_pkg::cmd_type      cmd
);
   import wsw_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;
   localparam logic [2:0] S_OUT    = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.load = req_valid && req_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.exit_go ? S_READ : S_OUT;
         end
         S_READ: begin
            cmd.scan = 1'b1;
            cmd.rd   = sts.rd_go;
            state_in = sts.rd_go ? S_CHECK : S_FINISH;
         end
         S_CHECK: begin
            cmd.chk  = 1'b1;
            state_in = sts.older ? S_READ : S_FINISH;
         end
         S_FINISH: begin
            cmd.fin  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            cmd.out = slot_free;
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/wsw_dp.sv =====
// Datapath of the worker supervisor watchdog: state, timers and crash ring.
`timescale 1ns / 1ps
`default_nettype none
module wsw_dp #(
   parameter int CRASH_DEPTH  = 16,
   parameter int BACKOFF_UNIT = 1000
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire wsw_pkg::cmd_type         cmd,
   output wsw_pkg::sts_type              sts,
   input  wire wsw_pkg::cfg_type         cfg,
   input  wire logic [3:0]               req_func,
   input  wire logic [wsw_pkg::TW-1:0]   req_stamp,
   input  wire logic [wsw_pkg::SW-1:0]   req_slide_id,
   output logic [1:0]                    rsp_action,
   output logic                          rsp_ping_due,
   output logic                          rsp_gave_up_flag,
   output logic                          rsp_poison_valid,
   output logic [wsw_pkg::SW-1:0]        rsp_poison_slide
);
   import wsw_pkg::*;

   localparam int IW = (CRASH_DEPTH > 1) ? $clog2(CRASH_DEPTH) : 1;
   localparam int FW = $clog2(CRASH_DEPTH + 1);

   function automatic logic [IW-1:0] wrap(input logic [IW-1:0] base,
                                          input logic [FW-1:0] off);
      logic [IW:0] s;
      s = {1'b0, base} + (IW+1)'(off);
      if (s >= (IW+1)'(CRASH_DEPTH)) s = s - (IW+1)'(CRASH_DEPTH);
      return s[IW-1:0];
   endfunction

   function automatic logic over(input logic [TW-1:0] now, input logic [TW-1:0] t,
                                 input logic [TW-1:0] lim);
      return (now >= t) && ((now - t) > lim);
   endfunction

   function automatic logic at_least(input logic [TW-1:0] now, input logic [TW-1:0] t,
                                     input logic [TW-1:0] lim);
      return (now >= t) && ((now - t) >= lim);
   endfunction

   // latched transfer
   logic [3:0]    func_ff;
   logic [TW-1:0] now_ff;
   logic [SW-1:0] slide_ff;

   // supervisor state
   logic started_ff, spawned_ff, killing_ff, restart_ff, pend_spawn_ff, gave_up_ff;
   logic ping_out_ff, frame_out_ff, busy_ff, poison_held_ff;
   logic [TW-1:0] spawn_at_ff, spawned_time_ff, last_ping_ff, ping_time_ff;
   logic [TW-1:0] frame_time_ff, busy_since_ff, wait_since_ff;
   logic [SW-1:0] busy_id_ff, poison_id_ff, pend_cnt_ff;
   logic [4:0]    step_ff;

   // per event results
   logic [1:0]    action_ff;
   logic          pv_ff;
   logic [SW-1:0] ps_ff;

   // crash ring
   logic [TW-1:0] ring_mem [CRASH_DEPTH];
   logic [IW-1:0] head_ff;
   logic [FW-1:0] fill_ff, drop_ff;
   logic [TW-1:0] rd_data_ff, cut_ff, delay_ff;

   // exit bookkeeping
   logic          old_life;
   logic [FW-1:0] fill0, fill1, fill_left;
   logic          ring_full;
   logic [IW-1:0] head1, waddr, raddr;
   logic          compiling, overdue;
   logic [4:0]    shamt;
   logic [63:0]   dshift;
   logic [TW-1:0] delay_in;
   logic [TW:0]   spawn_sum;

   assign old_life  = at_least(now_ff, spawned_time_ff, cfg.storm_window);
   assign fill0     = old_life ? '0 : fill_ff;
   assign ring_full = (fill0 >= FW'(CRASH_DEPTH));
   assign fill1     = ring_full ? FW'(CRASH_DEPTH - 1) : fill0;
   assign head1     = ring_full ? wrap(head_ff, FW'(1)) : head_ff;
   assign waddr     = wrap(head1, fill1);
   assign raddr     = wrap(head_ff, drop_ff);
   assign fill_left = fill_ff - drop_ff;

   assign sts.exit_go = (func_ff == EV_EXIT) && spawned_ff;
   assign sts.rd_go   = (now_ff >= cfg.storm_window) && (drop_ff < fill_ff);
   assign sts.older   = rd_data_ff < cut_ff;

   assign compiling = busy_ff || (pend_cnt_ff != '0);
   assign overdue =
      (ping_out_ff && over(now_ff, ping_time_ff, cfg.pong_wait)) ||
      (busy_ff && over(now_ff, busy_since_ff, cfg.compile_wait)) ||
      (!busy_ff && (pend_cnt_ff != '0) && over(now_ff, wait_since_ff, cfg.compile_wait)) ||
      (frame_out_ff && !compiling && over(now_ff, frame_time_ff, cfg.frame_wait));

   // backoff: unit doubled per step, capped
   assign shamt  = (step_ff - 5'd1 > SHIFT_MAX) ? SHIFT_MAX : step_ff - 5'd1;
   assign dshift = 64'(BACKOFF_UNIT) << shamt;
   always_comb begin
      if (step_ff == 5'd0) delay_in = '0;
      else if (dshift < {16'd0, cfg.backoff_cap}) delay_in = dshift[TW-1:0];
      else delay_in = cfg.backoff_cap;
   end
   assign spawn_sum = {1'b0, now_ff} + {1'b0, delay_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         now_ff   <= req_stamp;
         slide_ff <= req_slide_id;
      end
      if (cmd.exec && sts.exit_go) ring_mem[waddr] <= now_ff;
      if (cmd.rd) rd_data_ff <= ring_mem[raddr];
      if (cmd.exec) cut_ff <= now_ff - cfg.storm_window;
      if (cmd.scan) delay_ff <= delay_in;
      if (cmd.out) begin
         rsp_action       <= action_ff;
         rsp_ping_due     <= spawned_ff && !killing_ff && !ping_out_ff &&
                             at_least(now_ff, last_ping_ff, cfg.ping_period);
         rsp_gave_up_flag <= gave_up_ff;
         rsp_poison_valid <= pv_ff;
         rsp_poison_slide <= ps_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0; spawned_ff <= 1'b0; killing_ff <= 1'b0;
         restart_ff <= 1'b0; pend_spawn_ff <= 1'b0; gave_up_ff <= 1'b0;
         ping_out_ff <= 1'b0; frame_out_ff <= 1'b0; busy_ff <= 1'b0;
         poison_held_ff <= 1'b0;
         spawn_at_ff <= '0; spawned_time_ff <= '0; last_ping_ff <= '0;
         ping_time_ff <= '0; frame_time_ff <= '0; busy_since_ff <= '0;
         wait_since_ff <= '0;
         busy_id_ff <= '0; poison_id_ff <= '0; pend_cnt_ff <= '0;
         step_ff <= '0; head_ff <= '0; fill_ff <= '0; drop_ff <= '0;
         action_ff <= ACT_NONE; pv_ff <= 1'b0; ps_ff <= '0;
      end else begin
         if (cmd.load) begin
            action_ff <= ACT_NONE;
            pv_ff     <= 1'b0;
            ps_ff     <= '0;
            drop_ff   <= '0;
         end
         if (cmd.exec) begin
            case (func_ff)
               EV_UPDATE: begin
                  if (started_ff && !gave_up_ff) begin
                     if (!spawned_ff) begin
                        if (pend_spawn_ff && now_ff >= spawn_at_ff) begin
                           pend_spawn_ff <= 1'b0;
                           action_ff     <= ACT_SPAWN;
                        end
                     end else if (!killing_ff) begin
                        if (restart_ff) begin
                           restart_ff <= 1'b0;
                           killing_ff <= 1'b1;
                           action_ff  <= ACT_KILL;
                        end else if (overdue) begin
                           killing_ff <= 1'b1;
                           action_ff  <= ACT_KILL;
                        end
                     end
                  end
               end
               EV_START: begin
                  if (!started_ff) begin
                     started_ff    <= 1'b1;
                     pend_spawn_ff <= 1'b1;
                     spawn_at_ff   <= now_ff;
                  end
               end
               EV_SPAWNED: begin
                  spawned_ff <= 1'b1; killing_ff <= 1'b0; pend_spawn_ff <= 1'b0;
                  spawned_time_ff <= now_ff; last_ping_ff <= now_ff;
                  ping_out_ff <= 1'b0; frame_out_ff <= 1'b0;
                  busy_ff <= 1'b0; busy_id_ff <= '0; pend_cnt_ff <= '0;
               end
               EV_EXIT: begin
                  if (spawned_ff) begin
                     spawned_ff <= 1'b0; killing_ff <= 1'b0; restart_ff <= 1'b0;
                     ping_out_ff <= 1'b0; frame_out_ff <= 1'b0;
                     if (busy_ff) begin
                        poison_held_ff <= 1'b1;
                        poison_id_ff   <= busy_id_ff;
                     end
                     busy_ff <= 1'b0; busy_id_ff <= '0; pend_cnt_ff <= '0;
                     if (old_life) step_ff <= '0;
                     head_ff <= head1;
                     fill_ff <= fill1 + FW'(1);
                  end
               end
               EV_PING: begin
                  ping_out_ff <= 1'b1; ping_time_ff <= now_ff; last_ping_ff <= now_ff;
               end
               EV_PONG:   ping_out_ff <= 1'b0;
               EV_FBEGIN: begin
                  frame_out_ff <= 1'b1; frame_time_ff <= now_ff;
               end
               EV_FDONE:  frame_out_ff <= 1'b0;
               EV_SUBMIT: begin
                  if (pend_cnt_ff == '0) wait_since_ff <= now_ff;
                  if (pend_cnt_ff != PEND_MAX) pend_cnt_ff <= pend_cnt_ff + SW'(1);
               end
               EV_BUSY: begin
                  busy_ff <= 1'b1; busy_id_ff <= slide_ff;
                  busy_since_ff <= now_ff; wait_since_ff <= now_ff;
               end
               EV_RESTART: begin
                  if (started_ff) begin
                     gave_up_ff <= 1'b0;
                     fill_ff    <= '0;
                     step_ff    <= '0;
                     if (spawned_ff) restart_ff <= 1'b1;
                     else begin
                        pend_spawn_ff <= 1'b1;
                        spawn_at_ff   <= now_ff;
                     end
                  end
               end
               EV_RESULT: begin
                  if (pend_cnt_ff != '0) pend_cnt_ff <= pend_cnt_ff - SW'(1);
                  wait_since_ff <= now_ff;
                  if (busy_ff && slide_ff == busy_id_ff) begin
                     busy_ff    <= 1'b0;
                     busy_id_ff <= '0;
                  end
                  if (frame_out_ff) frame_time_ff <= now_ff;
               end
               EV_TAKEPOIS: begin
                  if (poison_held_ff) begin
                     pv_ff <= 1'b1;
                     ps_ff <= poison_id_ff;
                  end
                  poison_held_ff <= 1'b0;
                  poison_id_ff   <= '0;
               end
               default: ;
            endcase
         end
         if (cmd.chk && sts.older) drop_ff <= drop_ff + FW'(1);
         if (cmd.fin) begin
            head_ff <= raddr;
            fill_ff <= fill_left;
            if (32'(fill_left) > 32'(cfg.storm_count)) gave_up_ff <= 1'b1;
            else begin
               spawn_at_ff   <= spawn_sum[TW] ? {TW{1'b1}} : spawn_sum[TW-1:0];
               if (step_ff != STEP_MAX) step_ff <= step_ff + 5'd1;
               pend_spawn_ff <= 1'b1;
            end
         end
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/worker_supervisor_watchdog_core.sv =====
// Top level of the worker supervisor watchdog: register file, sequencer and datapath.
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                                   Moves
// req       req_valid/req_ready, func stamp slide   one event per transfer
// rsp       rsp_valid/rsp_ready, action .. slide    one result per event
// csr       psel penable pwrite paddr pwdata prdata  64-bit registers at 8*i
//
// Steps: accept, execute and result per event; an exit of a running worker adds a
// walk that reads and checks each purged crash time and any kept entry it stops on,
// then a finish (fewer than CRASH_DEPTH purged, the new entry always stays).
// Reset clears all control state; the crash ring is never cleared, only entries
// below the fill count are read.
// A stalled result sits in the output register; the next event is taken and waits.
module worker_supervisor_watchdog_core #(
   parameter int CRASH_DEPTH  = wsw_pkg::CRASH_DEPTH_DEF,
   parameter int BACKOFF_UNIT = wsw_pkg::BACKOFF_UNIT_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [3:0]               req_func,
   input  wire logic [wsw_pkg::TW-1:0]   req_stamp,
   input  wire logic [wsw_pkg::SW-1:0]   req_slide_id,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [1:0]                    rsp_action,
   output logic                          rsp_ping_due,
   output logic                          rsp_gave_up_flag,
   output logic                          rsp_poison_valid,
   output logic [wsw_pkg::SW-1:0]        rsp_poison_slide,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [5:0]               paddr,
   input  wire logic [63:0]              pwdata,
   output logic [63:0]                   prdata,
   output logic                          pready
);
   import wsw_pkg::*;

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;
   logic    wr_fire;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[5:3];
   assign wr_fire = psel && penable && pwrite;

   // register file; a write to an unused slot is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.storm_window <= 48'd60000;
         cfg_ff.storm_count  <= 4'd5;
         cfg_ff.backoff_cap  <= 48'd30000;
         cfg_ff.pong_wait    <= 48'd5000;
         cfg_ff.compile_wait <= 48'd30000;
         cfg_ff.frame_wait   <= 48'd5000;
         cfg_ff.ping_period  <= 48'd1000;
      end else if (wr_fire) begin
         case (reg_idx)
            REG_STORM_WIN: cfg_ff.storm_window <= pwdata[TW-1:0];
            REG_STORM_CNT: cfg_ff.storm_count  <= pwdata[3:0];
            REG_BACKOFF:   cfg_ff.backoff_cap  <= pwdata[TW-1:0];
            REG_PONG:      cfg_ff.pong_wait    <= pwdata[TW-1:0];
            REG_COMPILE:   cfg_ff.compile_wait <= pwdata[TW-1:0];
            REG_FRAME:     cfg_ff.frame_wait   <= pwdata[TW-1:0];
            REG_PING:      cfg_ff.ping_period  <= pwdata[TW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_STORM_WIN: prdata = {16'd0, cfg_ff.storm_window};
         REG_STORM_CNT: prdata = {60'd0, cfg_ff.storm_count};
         REG_BACKOFF:   prdata = {16'd0, cfg_ff.backoff_cap};
         REG_PONG:      prdata = {16'd0, cfg_ff.pong_wait};
         REG_COMPILE:   prdata = {16'd0, cfg_ff.compile_wait};
         REG_FRAME:     prdata = {16'd0, cfg_ff.frame_wait};
         REG_PING:      prdata = {16'd0, cfg_ff.ping_period};
         default:       prdata = '0;
      endcase
   end

   wsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   wsw_dp #(
      .CRASH_DEPTH  (CRASH_DEPTH),
      .BACKOFF_UNIT (BACKOFF_UNIT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .cfg              (cfg_ff),
      .req_func         (req_func),
      .req_stamp        (req_stamp),
      .req_slide_id     (req_slide_id),
      .rsp_action       (rsp_action),
      .rsp_ping_due     (rsp_ping_due),
      .rsp_gave_up_flag (rsp_gave_up_flag),
      .rsp_poison_valid (rsp_poison_valid),
      .rsp_poison_slide (rsp_poison_slide)
   );

   // one event in flight: an accepted transfer closes the input
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input open while an event is in flight");

   a_poison_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_poison_valid) |-> (rsp_poison_slide == '0))
      else $error("poison slide set without poison valid");

   a_action_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_action == ACT_NONE || rsp_action == ACT_SPAWN ||
                     rsp_action == ACT_KILL))
      else $error("bad action code");

endmodule
`default_nettype wire

// ===== dv/worker_supervisor_watchdog_core_tb.sv =====
// Self-checking testbench of the worker supervisor watchdog core.
`timescale 1ns / 1ps
`default_nettype none
// The test drives timestamped events with valid/ready and checks every result
// against a predictor kept in this file or against a directed row's own result.
// The run has two parts:
//  - a directed table, walked in order: reset values, unknown events, the
//    guarded events before start, a full spawn / ping / compile / exit cycle
//    with a poisoned slide, a kill on restart, and the largest stamp.
//  - five random phases, one register setting each: defaults, tight limits,
//    all zero, all ones and a mix. Each phase mostly plays well-formed worker
//    lives, with noise events, unknown codes and time going backwards.
// Registers are written only while the block is idle. The sender works in
// bursts; the receiver stalls at a rate that changes per phase.
module worker_supervisor_watchdog_core_tb;
   import wsw_pkg::*;

   localparam logic [TW-1:0] TMAX = {TW{1'b1}};
   localparam int RING_N    = 16;
   localparam int STEP_UNIT = 1000;
   // longest exit: the full ring walk on top of a plain event, plus margin
   localparam int LAT_CYC   = 60;
   localparam int PHASE_N   = 130;

   typedef struct packed {
      logic [1:0]    action;
      logic          ping_due;
      logic          gave_up;
      logic          pv;
      logic [SW-1:0] ps;
   } verdict_type;

   typedef struct packed {
      logic [3:0]    func;
      logic [TW-1:0] stamp;
      logic [SW-1:0] slide;
      logic          typed;   // row carries its own expected result
      verdict_type   want;
   } step_row_type;

   // ---- DUT signals, inputs known from time zero ----
   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [3:0]    req_func = '0;
   logic [TW-1:0] req_stamp = '0;
   logic [SW-1:0] req_slide_id = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [1:0]    rsp_action;
   logic          rsp_ping_due;
   logic          rsp_gave_up_flag;
   logic          rsp_poison_valid;
   logic [SW-1:0] rsp_poison_slide;
   logic          psel = 1'b0;
   logic          penable = 1'b0;
   logic          pwrite = 1'b0;
   logic [5:0]    paddr = '0;
   logic [63:0]   pwdata = '0;
   logic [63:0]   prdata;
   logic          pready;

   worker_supervisor_watchdog_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_stamp(req_stamp), .req_slide_id(req_slide_id),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_action(rsp_action),
      .rsp_ping_due(rsp_ping_due), .rsp_gave_up_flag(rsp_gave_up_flag),
      .rsp_poison_valid(rsp_poison_valid), .rsp_poison_slide(rsp_poison_slide),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---- predictor copy of registers and state ----
   logic [TW-1:0] c_storm_win, c_backoff, c_pong, c_compile, c_frame, c_period;
   logic [3:0]    c_storm_cnt;

   logic          s_started, s_spawned, s_killing, s_restart, s_pending_spawn;
   logic          s_gave_up, s_ping_out, s_frame_out, s_busy, s_poison_held;
   logic [TW-1:0] s_spawn_at, s_spawned_at, s_last_ping, s_ping_at, s_frame_at;
   logic [TW-1:0] s_busy_since, s_wait_since;
   logic [SW-1:0] s_busy_id, s_poison_id, s_pend_cnt;
   logic [4:0]    s_step;
   logic [TW-1:0] crash_times [RING_N];
   int            crash_cnt;

   verdict_type   pending_results[$];
   int            err_count = 0;
   int            ready_pct = 100;
   int            burst_left = 0;
   int            max_gap = 0;
   logic [TW-1:0] tick;

   function automatic logic past_limit(logic [TW-1:0] now, logic [TW-1:0] t,
                                       logic [TW-1:0] lim);
      return now >= t && (now - t) > lim;
   endfunction

   function automatic logic reached(logic [TW-1:0] now, logic [TW-1:0] t,
                                    logic [TW-1:0] lim);
      return now >= t && (now - t) >= lim;
   endfunction

   function automatic logic [TW-1:0] respawn_delay();
      logic [63:0] d;
      int          sh;
      if (s_step == 0) return '0;
      sh = (s_step - 1 > 30) ? 30 : s_step - 1;
      d  = (64'd1 << sh) * STEP_UNIT;
      return (d < {16'd0, c_backoff}) ? d[TW-1:0] : c_backoff;
   endfunction

   task automatic crash_close(input logic [TW-1:0] now);
      logic [63:0]   sum;
      logic [TW-1:0] cut;
      int            drop;
      if (!s_spawned) return;
      s_spawned = 0; s_killing = 0; s_restart = 0; s_ping_out = 0; s_frame_out = 0;
      if (s_busy) begin
         s_poison_held = 1;
         s_poison_id = s_busy_id;
      end
      s_busy = 0; s_busy_id = '0; s_pend_cnt = '0;
      if (reached(now, s_spawned_at, c_storm_win)) begin
         s_step = '0;
         crash_cnt = 0;
      end
      if (crash_cnt >= RING_N) begin
         for (int i = 0; i < RING_N - 1; i++) crash_times[i] = crash_times[i+1];
         crash_cnt = RING_N - 1;
      end
      crash_times[crash_cnt] = now;
      crash_cnt++;
      if (now >= c_storm_win) begin
         cut = now - c_storm_win;
         drop = 0;
         while (drop < crash_cnt && crash_times[drop] < cut) drop++;
         for (int i = 0; i < crash_cnt - drop; i++) crash_times[i] = crash_times[i+drop];
         crash_cnt -= drop;
      end
      if (crash_cnt > c_storm_cnt) begin
         s_gave_up = 1;
         return;
      end
      sum = {16'd0, now} + {16'd0, respawn_delay()};
      s_spawn_at = (sum > {16'd0, TMAX}) ? TMAX : sum[TW-1:0];
      if (s_step < STEP_MAX) s_step++;
      s_pending_spawn = 1;
   endtask

   function automatic logic [1:0] update_action(logic [TW-1:0] now);
      logic compiling, overdue;
      if (!s_started || s_gave_up) return ACT_NONE;
      if (!s_spawned) begin
         if (s_pending_spawn && now >= s_spawn_at) begin
            s_pending_spawn = 0;
            return ACT_SPAWN;
         end
         return ACT_NONE;
      end
      if (s_killing) return ACT_NONE;
      if (s_restart) begin
         s_restart = 0;
         s_killing = 1;
         return ACT_KILL;
      end
      compiling = s_busy || s_pend_cnt != 0;
      overdue = (s_ping_out && past_limit(now, s_ping_at, c_pong)) ||
                (s_busy && past_limit(now, s_busy_since, c_compile)) ||
                (!s_busy && s_pend_cnt != 0 && past_limit(now, s_wait_since, c_compile)) ||
                (s_frame_out && !compiling && past_limit(now, s_frame_at, c_frame));
      if (overdue) begin
         s_killing = 1;
         return ACT_KILL;
      end
      return ACT_NONE;
   endfunction

   // Applies one event to the predictor state and returns its result.
   task automatic supervise(input logic [3:0] func, input logic [TW-1:0] now,
                            input logic [SW-1:0] slide, output verdict_type v);
      v = '0;
      case (func)
         EV_UPDATE: v.action = update_action(now);
         EV_START: begin
            if (!s_started) begin
               s_started = 1; s_pending_spawn = 1; s_spawn_at = now;
            end
         end
         EV_SPAWNED: begin
            s_spawned = 1; s_killing = 0; s_pending_spawn = 0;
            s_spawned_at = now; s_last_ping = now;
            s_ping_out = 0; s_frame_out = 0; s_busy = 0; s_busy_id = '0; s_pend_cnt = '0;
         end
         EV_EXIT:   crash_close(now);
         EV_PING: begin
            s_ping_out = 1; s_ping_at = now; s_last_ping = now;
         end
         EV_PONG:   s_ping_out = 0;
         EV_FBEGIN: begin
            s_frame_out = 1; s_frame_at = now;
         end
         EV_FDONE:  s_frame_out = 0;
         EV_SUBMIT: begin
            if (s_pend_cnt == 0) s_wait_since = now;
            if (s_pend_cnt != PEND_MAX) s_pend_cnt++;
         end
         EV_BUSY: begin
            s_busy = 1; s_busy_id = slide; s_busy_since = now; s_wait_since = now;
         end
         EV_RESTART: begin
            if (s_started) begin
               s_gave_up = 0; crash_cnt = 0; s_step = '0;
               if (s_spawned) s_restart = 1;
               else begin
                  s_pending_spawn = 1; s_spawn_at = now;
               end
            end
         end
         EV_RESULT: begin
            if (s_pend_cnt != 0) s_pend_cnt--;
            s_wait_since = now;
            if (s_busy && slide == s_busy_id) begin
               s_busy = 0; s_busy_id = '0;
            end
            if (s_frame_out) s_frame_at = now;
         end
         EV_TAKEPOIS: begin
            if (s_poison_held) begin
               v.pv = 1; v.ps = s_poison_id;
            end
            s_poison_held = 0; s_poison_id = '0;
         end
         default: ;
      endcase
      v.ping_due = s_spawned && !s_killing && !s_ping_out &&
                   reached(now, s_last_ping, c_period);
      v.gave_up = s_gave_up;
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("%0t mismatch %s: expected %0h got %0h", $realtime, what, want, got);
      err_count++;
   endtask

   // ---- result channel: stall pattern and checking ----
   always @(posedge clock) begin
      verdict_type w;
      rsp_ready <= ($urandom_range(0, 99) < ready_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result transfer", 0, 1);
         end else begin
            w = pending_results[0];
            pending_results.delete(0);
            if (rsp_action !== w.action)         report_mismatch("action", w.action, rsp_action);
            if (rsp_ping_due !== w.ping_due)     report_mismatch("ping_due", w.ping_due, rsp_ping_due);
            if (rsp_gave_up_flag !== w.gave_up)  report_mismatch("gave_up", w.gave_up, rsp_gave_up_flag);
            if (rsp_poison_valid !== w.pv)       report_mismatch("poison_valid", w.pv, rsp_poison_valid);
            if (rsp_poison_slide !== w.ps)       report_mismatch("poison_slide", w.ps, rsp_poison_slide);
         end
      end
   end

   // ---- stimulus ----
   // Register write: setup cycle then access cycle; called at a rising edge.
   task automatic csr_write(input logic [2:0] idx, input logic [TW-1:0] val);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 3'b000}; pwdata <= {16'd0, val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_STORM_WIN: c_storm_win = val;
         REG_STORM_CNT: c_storm_cnt = val[3:0];
         REG_BACKOFF:   c_backoff   = val;
         REG_PONG:      c_pong      = val;
         REG_COMPILE:   c_compile   = val;
         REG_FRAME:     c_frame     = val;
         REG_PING:      c_period    = val;
         default: ;
      endcase
   endtask

   // One event transfer; typed rows queue their own expectation.
   task automatic push_event(input logic [3:0] func, input logic [TW-1:0] stamp,
                             input logic [SW-1:0] slide, input logic typed,
                             input verdict_type want, output verdict_type got);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1; req_func <= func; req_stamp <= stamp; req_slide_id <= slide;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      supervise(func, stamp, slide, got);
      pending_results.insert(pending_results.size(), typed ? want : got);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LAT_CYC) @(posedge clock);
   endtask

   step_row_type directed_rows[] = '{
      '{EV_UPDATE,   48'd0,  16'h0000, 1'b1, '0},            // nothing started
      '{4'd13,       48'd5,  16'h0000, 1'b1, '0},            // unknown codes do nothing
      '{4'd14,       48'd6,  16'hFFFF, 1'b1, '0},
      '{4'd15,       TMAX,   16'h5555, 1'b1, '0},
      '{EV_TAKEPOIS, 48'd10, 16'h0000, 1'b1, '0},            // nothing held
      '{EV_RESTART,  48'd10, 16'h0000, 1'b1, '0},            // before start: ignored
      '{EV_EXIT,     48'd20, 16'h0000, 1'b1, '0},            // not spawned: ignored
      '{EV_START,    48'd100, 16'h0000, 1'b0, '0},
      '{EV_UPDATE,   48'd100, 16'h0000, 1'b1, '{ACT_SPAWN, 1'b0, 1'b0, 1'b0, 16'h0}},
      '{EV_SPAWNED,  48'd200, 16'h0000, 1'b0, '0},
      '{EV_UPDATE,   48'd1300, 16'h0000, 1'b0, '0},
      '{EV_PING,     48'd1300, 16'h0000, 1'b0, '0},
      '{EV_PONG,     48'd1400, 16'h0000, 1'b0, '0},
      '{EV_FBEGIN,   48'd1500, 16'h0000, 1'b0, '0},
      '{EV_SUBMIT,   48'd1500, 16'h0000, 1'b0, '0},
      '{EV_BUSY,     48'd1600, 16'hFFFF, 1'b0, '0},
      '{EV_RESULT,   48'd1700, 16'h1234, 1'b0, '0},          // wrong slide keeps busy
      '{EV_EXIT,     48'd2000, 16'h0000, 1'b0, '0},          // dies while compiling
      '{EV_TAKEPOIS, 48'd2100, 16'h0000, 1'b1, '{ACT_NONE, 1'b0, 1'b0, 1'b1, 16'hFFFF}},
      '{EV_UPDATE,   48'd3000, 16'h0000, 1'b0, '0},
      '{EV_SPAWNED,  48'd3100, 16'h0000, 1'b0, '0},
      '{EV_RESTART,  48'd3200, 16'h0000, 1'b0, '0},
      '{EV_UPDATE,   48'd3300, 16'h0000, 1'b1, '{ACT_KILL, 1'b0, 1'b0, 1'b0, 16'h0}},
      '{EV_EXIT,     TMAX,    16'h0000, 1'b0, '0},           // spawn time lands on the largest stamp
      '{EV_UPDATE,   48'd50,  16'h0000, 1'b0, '0}            // time goes backwards
   };

   // Picks the next event of a worker life, steered by the predicted state.
   function automatic logic [3:0] pick_event(logic [1:0] last_act);
      int r;
      if (!s_started) return EV_START;
      if (last_act == ACT_SPAWN && $urandom_range(0, 9) < 9) return EV_SPAWNED;
      if (last_act == ACT_KILL && $urandom_range(0, 9) < 8) return EV_EXIT;
      r = $urandom_range(0, 99);
      if (r < 30) return EV_UPDATE;
      if (r < 38) return EV_PING;
      if (r < 45) return EV_PONG;
      if (r < 51) return EV_FBEGIN;
      if (r < 57) return EV_FDONE;
      if (r < 64) return EV_SUBMIT;
      if (r < 70) return EV_BUSY;
      if (r < 77) return EV_RESULT;
      if (r < 84) return EV_EXIT;
      if (r < 88) return EV_SPAWNED;
      if (r < 91) return EV_RESTART;
      if (r < 95) return EV_TAKEPOIS;
      if (r < 97) return EV_START;
      return 4'($urandom_range(13, 15));
   endfunction

   task automatic random_phase(input logic [TW-1:0] base, input logic [TW-1:0] span);
      logic [1:0]    last_act;
      logic [3:0]    func;
      logic [SW-1:0] slide;
      logic [63:0]   step, sum;
      verdict_type   v;
      tick = base;
      last_act = ACT_NONE;
      for (int n = 0; n < PHASE_N; n++) begin
         step = {$urandom, $urandom} % ({16'd0, span} + 64'd1);
         if ($urandom_range(0, 99) < 3) tick = tick - step[TW-1:0];   // backwards
         else begin
            sum = {16'd0, tick} + step;
            tick = (sum > {16'd0, TMAX}) ? TMAX : sum[TW-1:0];
         end
         func = pick_event(last_act);
         slide = (func == EV_RESULT && $urandom_range(0, 1)) ? s_busy_id : 16'($urandom);
         push_event(func, tick, slide, 1'b0, '0, v);
         last_act = v.action;
      end
      drain();
   endtask

   task automatic set_all(input logic [TW-1:0] win, input logic [3:0] cnt,
                          input logic [TW-1:0] cap, input logic [TW-1:0] pong,
                          input logic [TW-1:0] comp, input logic [TW-1:0] frm,
                          input logic [TW-1:0] per);
      csr_write(REG_STORM_WIN, win);
      csr_write(REG_STORM_CNT, {44'd0, cnt});
      csr_write(REG_BACKOFF, cap);
      csr_write(REG_PONG, pong);
      csr_write(REG_COMPILE, comp);
      csr_write(REG_FRAME, frm);
      csr_write(REG_PING, per);
   endtask

   initial begin
      verdict_type v;
      // reset values of registers and state
      c_storm_win = 48'd60000; c_storm_cnt = 4'd5; c_backoff = 48'd30000;
      c_pong = 48'd5000; c_compile = 48'd30000; c_frame = 48'd5000; c_period = 48'd1000;
      {s_started, s_spawned, s_killing, s_restart, s_pending_spawn} = '0;
      {s_gave_up, s_ping_out, s_frame_out, s_busy, s_poison_held} = '0;
      {s_spawn_at, s_spawned_at, s_last_ping, s_ping_at, s_frame_at} = '0;
      {s_busy_since, s_wait_since, s_busy_id, s_poison_id, s_pend_cnt, s_step} = '0;
      crash_cnt = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, reset settings, mild stalls
      ready_pct = 70; max_gap = 3;
      foreach (directed_rows[i])
         push_event(directed_rows[i].func, directed_rows[i].stamp, directed_rows[i].slide,
                    directed_rows[i].typed, directed_rows[i].want, v);
      drain();   // sender holds off until every result is back

      // defaults written back, no idling on either side
      ready_pct = 100; max_gap = 0;
      set_all(48'd60000, 4'd5, 48'd30000, 48'd5000, 48'd30000, 48'd5000, 48'd1000);
      random_phase(48'd0, 48'd4000);

      // tight limits: storms and timeouts come often
      ready_pct = 30; max_gap = 6;
      set_all(48'd3000, 4'd2, 48'd4000, 48'd300, 48'd800, 48'd400, 48'd100);
      random_phase(48'd100000, 48'd300);

      // all zero
      ready_pct = 60; max_gap = 2;
      set_all('0, 4'd0, '0, '0, '0, '0, '0);
      random_phase(48'd200000, 48'd5);

      // all ones, stamps near the top of the range
      ready_pct = 80; max_gap = 5;
      set_all(TMAX, 4'd15, TMAX, TMAX, TMAX, TMAX, TMAX);
      random_phase(48'hFFFF_0000_0000, 48'hFFFF_FFFF);

      // mixed
      ready_pct = 50; max_gap = 4;
      set_all(48'd20000, 4'd15, TMAX, 48'd2000, 48'd5000, 48'd1500, 48'd500);
      random_phase(48'd300000, 48'd1500);

      if (err_count == 0)
         $display("worker_supervisor_watchdog_core regression: pass");
      else
         $display("worker_supervisor_watchdog_core regression: fail");
      $finish;
   end

   // run limit, far above the slowest legal run
   initial begin
      #4ms;
      $display("worker_supervisor_watchdog_core regression: fail");
      $finish;
   end

endmodule
`default_nettype wire
